@@ src/rcbl_pkg.sv @@
// Shared constants, register map and helper functions for the RGB color blob locator.
// Depends on nothing; the top level imports it.
`default_nettype none

package rcbl_pkg;

  // Fixed field widths.
  localparam int CFG_DIM_W = 11;
  localparam int COUNT_W   = 21;
  localparam int RANGE_W   = 48;
  localparam int OUT_POS_W = 10;
  localparam int CHAN_W    = 8;

  // Register port.
  localparam int PDATA_W   = 64;
  localparam int PADDR_W   = 6;
  localparam int REG_IDX_W = 3;
  localparam int REG_LSB   = 3;

  // Number of color range registers in the register map.
  localparam int RANGE_REG_COUNT = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FRAME_WIDTH       = 3'd0,
    REG_FRAME_HEIGHT      = 3'd1,
    REG_MIN_OBJECT_PIXELS = 3'd2,
    REG_BLUE_RANGES       = 3'd3,
    REG_YELLOW_RANGES     = 3'd4,
    REG_ORANGE_RANGES     = 3'd5
  } reg_idx_e;

  localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;
  localparam logic [COUNT_W-1:0]   MIN_PIXELS_RST   = 21'd30;

  localparam logic [RANGE_W-1:0] BLUE_RANGES_RST   = 48'h000A155E30FF;
  localparam logic [RANGE_W-1:0] YELLOW_RANGES_RST = 48'hC8FFB4FF0064;
  localparam logic [RANGE_W-1:0] ORANGE_RANGES_RST = 48'h88FA1B38000A;

  // Reset value of the range register of one color; colors without a register get zero.
  function automatic logic [RANGE_W-1:0] range_reset(input int color);
    logic [RANGE_W-1:0] value;
    case (color)
      0:       value = BLUE_RANGES_RST;
      1:       value = YELLOW_RANGES_RST;
      2:       value = ORANGE_RANGES_RST;
      default: value = '0;
    endcase
    return value;
  endfunction

  // True when every channel lies within its inclusive min/max pair.
  // The pairs are packed rmin,rmax,gmin,gmax,bmin,bmax from high to low.
  function automatic logic pixel_in_box(input logic [RANGE_W-1:0] rg,
                                        input logic [CHAN_W-1:0] r,
                                        input logic [CHAN_W-1:0] g,
                                        input logic [CHAN_W-1:0] b);
    logic r_ok;
    logic g_ok;
    logic b_ok;
    r_ok = (r >= rg[47:40]) && (r <= rg[39:32]);
    g_ok = (g >= rg[31:24]) && (g <= rg[23:16]);
    b_ok = (b >= rg[15:8])  && (b <= rg[7:0]);
    return r_ok && g_ok && b_ok;
  endfunction

endpackage

`default_nettype wire

@@ src/rgb_color_blob_locator.sv @@
// RGB color blob locator: per-color threshold match, pixel count and bounding box per frame.
// Depends on rcbl_pkg for the register map, fixed widths and the range compare.
//
// Usage:
//   Pixels enter in raster order on the input channel (in_valid_i, in_stall_o, red_i, green_i,
//   blue_i), one transaction per pixel. The block tracks the column and row of each pixel
//   against the effective frame size, where a size of zero acts as one and a size above
//   MAX_DIMENSION acts as MAX_DIMENSION.
//   After the last pixel of a frame the output channel (out_valid_o, out_stall_i and the
//   result fields) carries COLOR_COUNT transactions, one per color in color order, the final
//   one flagged by last_result_o.
//   Throughput is one pixel per cycle while the input does not stall. The last pixel of a frame
//   passes the input register and the result bank before the first result is loaded into the
//   output register, and results then follow one per cycle while the receiver takes them.
//   A finished frame is copied into a result bank, so the next frame streams in while the
//   results drain. The input stalls only when a frame's last pixel arrives while the bank still
//   holds or is about to take the previous frame, which for frames of at least COLOR_COUNT + 2
//   pixels never happens unless the output receiver stalls.
//   When the receiver stalls, the current result holds and the bank waits behind it.
//   Reset clears the position counters, the accumulators and the channel state, and loads
//   the register defaults. Registers are written over the APB-style port, 8 bytes apart.
`default_nettype none

module rgb_color_blob_locator #(
  parameter int MAX_DIMENSION = 1024,
  parameter int COLOR_COUNT   = 3
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Register port.
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rcbl_pkg::PADDR_W-1:0]           paddr,
  input  logic [rcbl_pkg::PDATA_W-1:0]           pwdata,
  output logic [rcbl_pkg::PDATA_W-1:0]           prdata,
  output logic                                   pready,
  // Pixel input channel.
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [rcbl_pkg::CHAN_W-1:0]            red_i,
  input  logic [rcbl_pkg::CHAN_W-1:0]            green_i,
  input  logic [rcbl_pkg::CHAN_W-1:0]            blue_i,
  // Result output channel.
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [1:0]                             color_index_o,
  output logic                                   object_found_o,
  output logic [rcbl_pkg::OUT_POS_W-1:0]         center_col_o,
  output logic [rcbl_pkg::OUT_POS_W-1:0]         center_row_o,
  output logic signed [rcbl_pkg::OUT_POS_W-1:0]  radius_o,
  output logic [rcbl_pkg::COUNT_W-1:0]           pixel_count_o,
  output logic                                   last_result_o
);

  import rcbl_pkg::*;

  // Positions run up to MAX_DIMENSION - 1; size compares need room for MAX_DIMENSION itself.
  localparam int POS_W = (MAX_DIMENSION > 2) ? $clog2(MAX_DIMENSION) : 1;
  localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int CMP_W = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
  localparam int IDX_W = (COLOR_COUNT > 1) ? $clog2(COLOR_COUNT) : 1;

  localparam logic [CMP_W-1:0] MaxDim   = CMP_W'(MAX_DIMENSION);
  localparam logic [IDX_W-1:0] LastIdx  = IDX_W'(COLOR_COUNT - 1);
  localparam logic [POS_W-1:0] PosOnes  = '1;
  localparam logic [COUNT_W-1:0] CntMax = '1;

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------
  logic [CFG_DIM_W-1:0] frame_width_q;
  logic [CFG_DIM_W-1:0] frame_height_q;
  logic [COUNT_W-1:0]   min_pixels_q;
  logic [RANGE_W-1:0]   range_q [COLOR_COUNT];

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[REG_LSB +: REG_IDX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      min_pixels_q   <= MIN_PIXELS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:       frame_width_q  <= pwdata[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT:      frame_height_q <= pwdata[CFG_DIM_W-1:0];
        REG_MIN_OBJECT_PIXELS: min_pixels_q   <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Only the first RANGE_REG_COUNT colors have a writable range; any further color keeps zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < COLOR_COUNT; c++) begin
        range_q[c] <= range_reset(c);
      end
    end else begin
      for (int c = 0; c < COLOR_COUNT; c++) begin
        if (cfg_wr && (c < RANGE_REG_COUNT) &&
            (cfg_idx == REG_IDX_W'(int'(REG_BLUE_RANGES) + c))) begin
          range_q[c] <= pwdata[RANGE_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_FRAME_WIDTH:       prdata = PDATA_W'(frame_width_q);
      REG_FRAME_HEIGHT:      prdata = PDATA_W'(frame_height_q);
      REG_MIN_OBJECT_PIXELS: prdata = PDATA_W'(min_pixels_q);
      default: begin
        for (int c = 0; c < COLOR_COUNT; c++) begin
          if ((c < RANGE_REG_COUNT) && (cfg_idx == REG_IDX_W'(int'(REG_BLUE_RANGES) + c))) begin
            prdata = PDATA_W'(range_q[c]);
          end
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Raster position and frame end detection
  // ---------------------------------------------------------------------------------------
  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] height_eff;
  logic [POS_W-1:0] col_q, row_q;
  logic             col_end, row_end, frame_end;
  logic             in_accept;

  always_comb begin
    if (frame_width_q == '0) begin
      width_eff = CMP_W'(1);
    end else if (CMP_W'(frame_width_q) > MaxDim) begin
      width_eff = MaxDim;
    end else begin
      width_eff = CMP_W'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_eff = CMP_W'(1);
    end else if (CMP_W'(frame_height_q) > MaxDim) begin
      height_eff = MaxDim;
    end else begin
      height_eff = CMP_W'(frame_height_q);
    end
  end

  // A shrunk size mid-frame still ends the row or frame, since the compare is at-or-beyond.
  assign col_end   = (CMP_W'(col_q) + CMP_W'(1)) >= width_eff;
  assign row_end   = (CMP_W'(row_q) + CMP_W'(1)) >= height_eff;
  assign frame_end = col_end && row_end;

  // ---------------------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------------------
  logic              s1_valid_q;
  logic              s1_eof_q;
  logic [CHAN_W-1:0] s1_red_q, s1_green_q, s1_blue_q;
  logic [POS_W-1:0]  s1_col_q, s1_row_q;
  logic              bank_busy_q;

  // A frame's last pixel waits while the result bank is still occupied or about to be.
  assign in_stall_o = frame_end && (bank_busy_q || (s1_valid_q && s1_eof_q));
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_eof_q   <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      s1_eof_q   <= in_accept && frame_end;
      if (in_accept) begin
        if (!col_end) begin
          col_q <= col_q + POS_W'(1);
        end else if (!row_end) begin
          col_q <= '0;
          row_q <= row_q + POS_W'(1);
        end else begin
          col_q <= '0;
          row_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_red_q   <= red_i;
      s1_green_q <= green_i;
      s1_blue_q  <= blue_i;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Per-color accumulators
  // ---------------------------------------------------------------------------------------
  logic [COUNT_W-1:0] acc_cnt_q  [COLOR_COUNT];
  logic [POS_W-1:0]   acc_rmin_q [COLOR_COUNT];
  logic [POS_W-1:0]   acc_rmax_q [COLOR_COUNT];
  logic [POS_W-1:0]   acc_cmin_q [COLOR_COUNT];
  logic [POS_W-1:0]   acc_cmax_q [COLOR_COUNT];

  logic [COUNT_W-1:0] nxt_cnt  [COLOR_COUNT];
  logic [POS_W-1:0]   nxt_rmin [COLOR_COUNT];
  logic [POS_W-1:0]   nxt_rmax [COLOR_COUNT];
  logic [POS_W-1:0]   nxt_cmin [COLOR_COUNT];
  logic [POS_W-1:0]   nxt_cmax [COLOR_COUNT];

  always_comb begin
    for (int c = 0; c < COLOR_COUNT; c++) begin
      nxt_cnt[c]  = acc_cnt_q[c];
      nxt_rmin[c] = acc_rmin_q[c];
      nxt_rmax[c] = acc_rmax_q[c];
      nxt_cmin[c] = acc_cmin_q[c];
      nxt_cmax[c] = acc_cmax_q[c];
      if (pixel_in_box(range_q[c], s1_red_q, s1_green_q, s1_blue_q)) begin
        if (acc_cnt_q[c] != CntMax) begin
          nxt_cnt[c] = acc_cnt_q[c] + COUNT_W'(1);
        end
        if (s1_row_q < acc_rmin_q[c]) nxt_rmin[c] = s1_row_q;
        if (s1_row_q > acc_rmax_q[c]) nxt_rmax[c] = s1_row_q;
        if (s1_col_q < acc_cmin_q[c]) nxt_cmin[c] = s1_col_q;
        if (s1_col_q > acc_cmax_q[c]) nxt_cmax[c] = s1_col_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < COLOR_COUNT; c++) begin
        acc_cnt_q[c]  <= '0;
        acc_rmin_q[c] <= PosOnes;
        acc_rmax_q[c] <= '0;
        acc_cmin_q[c] <= PosOnes;
        acc_cmax_q[c] <= '0;
      end
    end else if (s1_valid_q) begin
      for (int c = 0; c < COLOR_COUNT; c++) begin
        if (s1_eof_q) begin
          // The frame is complete: its totals go to the bank and the next frame starts clean.
          acc_cnt_q[c]  <= '0;
          acc_rmin_q[c] <= PosOnes;
          acc_rmax_q[c] <= '0;
          acc_cmin_q[c] <= PosOnes;
          acc_cmax_q[c] <= '0;
        end else begin
          acc_cnt_q[c]  <= nxt_cnt[c];
          acc_rmin_q[c] <= nxt_rmin[c];
          acc_rmax_q[c] <= nxt_rmax[c];
          acc_cmin_q[c] <= nxt_cmin[c];
          acc_cmax_q[c] <= nxt_cmax[c];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result bank: holds one finished frame while its results drain
  // ---------------------------------------------------------------------------------------
  logic [COUNT_W-1:0] bank_cnt_q  [COLOR_COUNT];
  logic [POS_W-1:0]   bank_rmin_q [COLOR_COUNT];
  logic [POS_W-1:0]   bank_rmax_q [COLOR_COUNT];
  logic [POS_W-1:0]   bank_cmin_q [COLOR_COUNT];
  logic [POS_W-1:0]   bank_cmax_q [COLOR_COUNT];
  logic [IDX_W-1:0]   idx_q;
  logic               out_load;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_eof_q) begin
      for (int c = 0; c < COLOR_COUNT; c++) begin
        bank_cnt_q[c]  <= nxt_cnt[c];
        bank_rmin_q[c] <= nxt_rmin[c];
        bank_rmax_q[c] <= nxt_rmax[c];
        bank_cmin_q[c] <= nxt_cmin[c];
        bank_cmax_q[c] <= nxt_cmax[c];
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result computation for the color the bank is pointing at
  // ---------------------------------------------------------------------------------------
  logic [COUNT_W-1:0] sel_cnt;
  logic [POS_W-1:0]   sel_rmin, sel_rmax, sel_cmin, sel_cmax;
  logic [POS_W-1:0]   half_col, half_row, half_max;
  logic               found;

  always_comb begin
    sel_cnt  = bank_cnt_q[0];
    sel_rmin = bank_rmin_q[0];
    sel_rmax = bank_rmax_q[0];
    sel_cmin = bank_cmin_q[0];
    sel_cmax = bank_cmax_q[0];
    for (int c = 1; c < COLOR_COUNT; c++) begin
      if (idx_q == IDX_W'(c)) begin
        sel_cnt  = bank_cnt_q[c];
        sel_rmin = bank_rmin_q[c];
        sel_rmax = bank_rmax_q[c];
        sel_cmin = bank_cmin_q[c];
        sel_cmax = bank_cmax_q[c];
      end
    end
  end

  // A found object has at least one match, so its box is never empty.
  assign found    = sel_cnt > min_pixels_q;
  assign half_col = (sel_cmax - sel_cmin) >> 1;
  assign half_row = (sel_rmax - sel_rmin) >> 1;
  assign half_max = (half_row > half_col) ? half_row : half_col;

  // ---------------------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------------------
  assign out_load = bank_busy_q && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      bank_busy_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_o <= 1'b1;
        if (idx_q == LastIdx) begin
          idx_q       <= '0;
          bank_busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + IDX_W'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      // The bank is always empty by the time a finished frame reaches it.
      if (s1_valid_q && s1_eof_q) begin
        bank_busy_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      color_index_o  <= 2'(idx_q);
      object_found_o <= found;
      pixel_count_o  <= sel_cnt;
      last_result_o  <= (idx_q == LastIdx);
      if (found) begin
        center_col_o <= OUT_POS_W'(sel_cmin + half_col);
        center_row_o <= OUT_POS_W'(sel_rmin + half_row);
        radius_o     <= OUT_POS_W'(half_max);
      end else begin
        center_col_o <= '0;
        center_row_o <= '0;
        radius_o     <= '1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  a_bank_free_at_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_eof_q) |-> !bank_busy_q)
    else $error("finished frame reached an occupied result bank");

  a_bank_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_eof_q) |=> (bank_busy_q && (idx_q == '0)))
    else $error("result bank did not take the finished frame");

  a_idx_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bank_busy_q |-> (idx_q == '0))
    else $error("result index not rewound with an empty bank");

  a_last_then_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (idx_q == LastIdx)) |=> (last_result_o && out_valid_o))
    else $error("final result of a frame not flagged");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_cnt_q[0] != '0) |-> ((acc_rmin_q[0] <= acc_rmax_q[0]) &&
                              (acc_cmin_q[0] <= acc_cmax_q[0])))
    else $error("bounding box inverted although pixels matched");

endmodule

`default_nettype wire
